### src/bpht_pkg.sv
// ---------------------------------------------------------------------------
// bpht_pkg
// Shared types and constants for the blocked probe hash table.
// ---------------------------------------------------------------------------
package bpht_pkg;

  localparam int Capacity      = 1024;
  localparam int SlotsPerBlock = 16;
  localparam int NumBlocks     = Capacity / SlotsPerBlock;
  localparam int BlkW          = $clog2(NumBlocks);
  localparam int SlotW         = $clog2(SlotsPerBlock);
  localparam int AddrW         = $clog2(Capacity);

  localparam logic [31:0] VacantKey      = 32'hDEADBEEF;
  localparam logic [31:0] PlaceholderKey = 32'h600DBEEF;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncLookup = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;
  localparam logic [1:0] StatSentinel = 2'd3;

  typedef struct packed {
    logic load;      // capture request, set block to home
    logic clr_start; // begin clearing pass
    logic rd;        // read current block
    logic next_blk;  // advance block
    logic wr_hit;    // apply hit action
    logic wr_free;   // insert into free slot
  } bpht_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic free;
    logic wrapped;   // all blocks visited after this one
    logic sentinel;
    logic [1:0] func;
  } bpht_stat_t;

endpackage

### src/blocked_probe_hash_table_core.sv
// ---------------------------------------------------------------------------
// blocked_probe_hash_table_core
// Hash table of 32-bit keys and 64-bit values in blocks of 16 slots.
// ---------------------------------------------------------------------------
// After reset a clearing pass (one block a cycle) runs over all 64 blocks before the
// first item is taken. Each item then reads each probed block, matches it and
// writes it back, and then presents its result; a full scan probes all 64 blocks.
// One item is in work at a time; the next is taken in the cycle its predecessor's
// result is taken.
module blocked_probe_hash_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [103:0]  s_tdata,  // func[1:0], key[33:2], value[97:34], zero pad
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata   // found[0], read_value[64:1], status[66:65], pad
);
  bpht_pkg::bpht_cmd_t  cmd;
  bpht_pkg::bpht_stat_t stat;
  logic [63:0] hit_value;
  logic        found, take;
  logic [1:0]  status;

  bpht_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_func(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_value(s_tdata[97:34]),
    .hit_value
  );

  bpht_ctrl u_ctrl (
    .clk, .rst, .cmd, .stat,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .res_found(found), .res_take_value(take), .res_status(status)
  );

  function automatic logic u_ctrl_eval_take(bpht_pkg::bpht_cmd_t c, bpht_pkg::bpht_stat_t s);
    u_ctrl_eval_take = !c.next_blk && s.hit && !s.sentinel &&
                       s.func == bpht_pkg::FuncLookup && !c.rd && !c.load;
  endfunction

  logic [63:0] rv;
  always_ff @(posedge clk) begin
    if (cmd.rd) rv <= '0;
    else if (u_ctrl_eval_take(cmd, stat)) rv <= hit_value;
  end

  assign m_tdata = {5'd0, status, (take ? rv : 64'd0), found};

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_hit && cmd.wr_free)) else $error("double write");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_nowr: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_free |-> !stat.sentinel) else $error("sentinel written");
endmodule

### src/bpht_datapath.sv
// ---------------------------------------------------------------------------
// bpht_datapath
// Block-wide key/value memories, slot match and write-back.
// ---------------------------------------------------------------------------
module bpht_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bpht_pkg::bpht_cmd_t  cmd,
  output bpht_pkg::bpht_stat_t stat,
  input  logic [1:0]           in_func,
  input  logic [31:0]          in_key,
  input  logic [63:0]          in_value,
  output logic [63:0]          hit_value
);
  localparam int S = bpht_pkg::SlotsPerBlock;

  logic [S*32-1:0] kmem [bpht_pkg::NumBlocks];
  logic [S*64-1:0] vmem [bpht_pkg::NumBlocks];
  logic [S*32-1:0] krow;
  logic [S*64-1:0] vrow;

  logic [1:0]  func;
  logic [31:0] key;
  logic [63:0] value;
  logic [bpht_pkg::BlkW-1:0] blk, home, clr_ptr;
  logic [bpht_pkg::BlkW:0]   visited;
  logic clearing;

  logic [S-1:0] match, vac;
  logic [bpht_pkg::SlotW-1:0] hit_idx, free_idx;
  logic [S*32-1:0] kw_hit, kw_free;
  logic [S*64-1:0] vw_hit, vw_free;

  always_comb begin
    home = in_key[bpht_pkg::AddrW-1:bpht_pkg::SlotW];
    for (int i = 0; i < S; i++) begin
      match[i] = krow[i*32 +: 32] == key;
      vac[i]   = krow[i*32 +: 32] == bpht_pkg::VacantKey;
    end
    hit_idx  = '0;
    free_idx = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = bpht_pkg::SlotW'(i);
      if (vac[i])   free_idx = bpht_pkg::SlotW'(i);
    end
    kw_hit  = krow;
    vw_hit  = vrow;
    if (func == bpht_pkg::FuncRemove) begin
      kw_hit[hit_idx*32 +: 32] = krow[(S-1)*32 +: 32];
      vw_hit[hit_idx*64 +: 64] = vrow[(S-1)*64 +: 64];
      if (!vac[S-1]) kw_hit[(S-1)*32 +: 32] = bpht_pkg::PlaceholderKey;
    end else begin
      vw_hit[hit_idx*64 +: 64] = value;
    end
    kw_free = krow;
    vw_free = vrow;
    kw_free[free_idx*32 +: 32] = key;
    vw_free[free_idx*64 +: 64] = value;
  end

  assign stat.clr_done = !clearing;
  assign stat.hit      = |match;
  assign stat.free     = vac[S-1];
  assign stat.wrapped  = visited == (bpht_pkg::BlkW+1)'(bpht_pkg::NumBlocks - 1);
  assign stat.sentinel = key == bpht_pkg::VacantKey || key == bpht_pkg::PlaceholderKey;
  assign stat.func     = func;
  assign hit_value     = vrow[hit_idx*64 +: 64];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b0;
      clr_ptr  <= '0;
    end else if (cmd.clr_start) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == bpht_pkg::BlkW'(bpht_pkg::NumBlocks - 1)) clearing <= 1'b0;
    end
    if (cmd.load) begin
      func    <= in_func;
      key     <= in_key;
      value   <= in_value;
      blk     <= home;
      visited <= '0;
    end else if (cmd.next_blk) begin
      blk     <= blk + 1'b1;
      visited <= visited + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      kmem[clr_ptr] <= {S{bpht_pkg::VacantKey}};
      vmem[clr_ptr] <= '0;
    end else if (cmd.wr_hit) begin
      kmem[blk] <= kw_hit;
      vmem[blk] <= vw_hit;
    end else if (cmd.wr_free) begin
      kmem[blk] <= kw_free;
      vmem[blk] <= vw_free;
    end
    if (cmd.rd) begin
      krow <= kmem[blk];
      vrow <= vmem[blk];
    end
  end
endmodule

### src/bpht_ctrl.sv
// ---------------------------------------------------------------------------
// bpht_ctrl
// Sequencer: clear, accept, probe blocks, write back, emit result.
// ---------------------------------------------------------------------------
module bpht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  output bpht_pkg::bpht_cmd_t  cmd,
  input  bpht_pkg::bpht_stat_t stat,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 res_found,
  output logic                 res_take_value,
  output logic [1:0]           res_status
);
  typedef enum logic [2:0] {ST_INIT, ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_OUT} state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE) || (state == ST_OUT && out_ready);
    cmd.clr_start = state == ST_INIT;
    cmd.load = in_valid && in_ready;
    cmd.rd = state == ST_READ;
    if (state == ST_EVAL && !stat.sentinel && stat.func != bpht_pkg::FuncUnused) begin
      if (stat.hit) begin
        cmd.wr_hit = stat.func != bpht_pkg::FuncLookup;
      end else if (stat.free) begin
        cmd.wr_free = stat.func == bpht_pkg::FuncInsert;
      end else if (!stat.wrapped) begin
        cmd.next_blk = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_INIT: state <= ST_CLEAR;
        ST_CLEAR: if (stat.clr_done) state <= ST_IDLE;
        ST_IDLE: if (cmd.load) state <= ST_READ;
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= cmd.load ? ST_READ : ST_IDLE;
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          if (cmd.next_blk) begin
            state <= ST_READ;
          end else begin
            state <= ST_OUT;
            out_valid <= 1'b1;
            if (stat.func == bpht_pkg::FuncUnused) begin
              res_found <= 1'b0;
              res_take_value <= 1'b0;
              res_status <= bpht_pkg::StatOk;
            end else if (stat.sentinel) begin
              res_found <= 1'b0;
              res_take_value <= 1'b0;
              res_status <= bpht_pkg::StatSentinel;
            end else if (stat.hit) begin
              res_found <= 1'b1;
              res_take_value <= stat.func == bpht_pkg::FuncLookup;
              res_status <= bpht_pkg::StatOk;
            end else if (stat.func == bpht_pkg::FuncInsert) begin
              res_found <= 1'b0;
              res_take_value <= 1'b0;
              res_status <= stat.free ? bpht_pkg::StatOk : bpht_pkg::StatFull;
            end else begin
              res_found <= 1'b0;
              res_take_value <= 1'b0;
              res_status <= bpht_pkg::StatNotFound;
            end
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end
endmodule

### sim/tb_blocked_probe_hash_table_core.sv
// ---------------------------------------------------------------------------
// tb_blocked_probe_hash_table_core
// Self-checking bench: directed and random insert, lookup, remove and unused items
// against a behavioral copy of the table, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_blocked_probe_hash_table_core;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] key;
    logic [1:0]  func;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic        found;
  } answer_t;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;

  blocked_probe_hash_table_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] keys_m [bpht_pkg::Capacity];
  logic [63:0] vals_m [bpht_pkg::Capacity];
  op_t     pending_ops [$];
  answer_t answers_due [$];
  logic [31:0] used_keys [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_long = 1'b0;

  // probe: 0 hit, 1 free slot, 2 exhausted
  function automatic int probe_table(input logic [31:0] k, output int slot);
    int blk;
    blk = (k % bpht_pkg::Capacity) / bpht_pkg::SlotsPerBlock;
    if (blk >= bpht_pkg::NumBlocks) blk = 0;
    slot = 0;
    for (int v = 0; v < bpht_pkg::NumBlocks; v++) begin
      int base;
      base = blk * bpht_pkg::SlotsPerBlock;
      for (int s = 0; s < bpht_pkg::SlotsPerBlock; s++)
        if (keys_m[base+s] == k) begin
          slot = base + s;
          return 0;
        end
      if (keys_m[base+bpht_pkg::SlotsPerBlock-1] == bpht_pkg::VacantKey)
        for (int s = 0; s < bpht_pkg::SlotsPerBlock; s++)
          if (keys_m[base+s] == bpht_pkg::VacantKey) begin
            slot = base + s;
            return 1;
          end
      blk = (blk + 1) % bpht_pkg::NumBlocks;
    end
    return 2;
  endfunction

  function automatic answer_t apply_op(input op_t op);
    answer_t a;
    int slot, r, last;
    a = '0;
    if (op.func == bpht_pkg::FuncUnused) return a;
    if (op.key == bpht_pkg::VacantKey || op.key == bpht_pkg::PlaceholderKey) begin
      a.status = bpht_pkg::StatSentinel;
      return a;
    end
    r = probe_table(op.key, slot);
    case (op.func)
      bpht_pkg::FuncInsert: begin
        if (r == 0) begin
          a.found = 1'b1;
          vals_m[slot] = op.value;
        end else if (r == 1) begin
          keys_m[slot] = op.key;
          vals_m[slot] = op.value;
        end else a.status = bpht_pkg::StatFull;
      end
      bpht_pkg::FuncLookup: begin
        if (r == 0) begin
          a.found = 1'b1;
          a.read_value = vals_m[slot];
        end else a.status = bpht_pkg::StatNotFound;
      end
      default: begin
        if (r == 0) begin
          last = slot - (slot % bpht_pkg::SlotsPerBlock) + bpht_pkg::SlotsPerBlock - 1;
          a.found = 1'b1;
          keys_m[slot] = keys_m[last];
          vals_m[slot] = vals_m[last];
          if (keys_m[last] != bpht_pkg::VacantKey) keys_m[last] = bpht_pkg::PlaceholderKey;
        end else a.status = bpht_pkg::StatNotFound;
      end
    endcase
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_op(input logic [1:0] f, input logic [31:0] k, input logic [63:0] v);
    op_t op;
    op.func = f;
    op.key = k;
    op.value = v;
    pending_ops.push_back(op);
    if (f == bpht_pkg::FuncInsert) used_keys.push_back(k);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (used_keys.size() > 0 && r < 6)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 8)  // crowd a few home blocks to force probing
      return {2'($urandom_range(0, 3)), 20'd0, 10'($urandom_range(0, 47))};
    return $urandom;
  endfunction

  // handshake seen at the last rising edge
  logic s_tready_q = 1'b0;
  always @(posedge clk) begin
    s_tready_q <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      answers_due.push_back(apply_op(s_tdata[97:0]));
  end

  // driver
  int gap_s = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (gap_s > 0) begin
          gap_s <= gap_s - 1;
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_s <= $urandom_range(1, 14);
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          s_tdata <= {6'd0, pending_ops.pop_front()};
          s_tvalid <= 1'b1;
        end else s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  int gap_m = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_long && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        m_tready <= 1'b0;
      end else if (gap_m > 0) begin
        gap_m <= gap_m - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_m <= $urandom_range(1, 14);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, exp_a;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata[66:0];
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_a = answers_due.pop_front();
          if (got.found !== exp_a.found)
            $display("%0t: found exp %0d got %0d", $time, exp_a.found, got.found);
          if (got.read_value !== exp_a.read_value)
            $display("%0t: read_value exp %h got %h", $time, exp_a.read_value,
                     got.read_value);
          if (got.status !== exp_a.status)
            $display("%0t: status exp %0d got %0d", $time, exp_a.status, got.status);
          if (got !== exp_a) errors++;
        end
      end
      if (idle_cycles > WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] k;
    int r;
    for (int i = 0; i < bpht_pkg::Capacity; i++) begin
      keys_m[i] = bpht_pkg::VacantKey;
      vals_m[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst = 1'b0;
    // directed
    queue_op(bpht_pkg::FuncLookup, 32'd5, '0);
    queue_op(bpht_pkg::FuncRemove, 32'd5, '0);
    queue_op(bpht_pkg::FuncInsert, 32'd5, '1);
    queue_op(bpht_pkg::FuncInsert, 32'd5, 64'h0123_4567_89ab_cdef);
    queue_op(bpht_pkg::FuncLookup, 32'd5, '1);
    queue_op(bpht_pkg::FuncInsert, 32'hFFFF_FFFF, '1);
    queue_op(bpht_pkg::FuncInsert, 32'h0, '0);
    queue_op(bpht_pkg::FuncLookup, 32'hFFFF_FFFF, '0);
    queue_op(bpht_pkg::FuncInsert, bpht_pkg::VacantKey, '1);
    queue_op(bpht_pkg::FuncLookup, bpht_pkg::PlaceholderKey, '0);
    queue_op(bpht_pkg::FuncRemove, bpht_pkg::VacantKey, '0);
    queue_op(bpht_pkg::FuncUnused, 32'd5, '1);
    for (int i = 0; i < 17; i++)  // overflow one block into the next
      queue_op(bpht_pkg::FuncInsert, 32'(i * bpht_pkg::Capacity + 32), 64'(i));
    queue_op(bpht_pkg::FuncRemove, 32'(15 * bpht_pkg::Capacity + 32), '0);
    queue_op(bpht_pkg::FuncRemove, 32'(32), '0);
    queue_op(bpht_pkg::FuncLookup, 32'(16 * bpht_pkg::Capacity + 32), '0);
    // long receiver hold while the sender keeps offering
    for (int i = 0; i < 20; i++) queue_op(bpht_pkg::FuncLookup, $urandom, '0);
    hold_long = 1'b1;
    // random
    for (int i = 0; i < 1400; i++) begin
      r = $urandom_range(0, 99);
      k = pick_key();
      if (r < 2) k = (r == 0) ? bpht_pkg::VacantKey : bpht_pkg::PlaceholderKey;
      if (r < 45) queue_op(bpht_pkg::FuncInsert, k, rand64());
      else if (r < 75) queue_op(bpht_pkg::FuncLookup, k, rand64());
      else if (r < 97) queue_op(bpht_pkg::FuncRemove, k, rand64());
      else queue_op(bpht_pkg::FuncUnused, k, rand64());
      if (i == 1150) begin
        wait (pending_ops.size() == 0);
        quiet = 1'b1;
      end
    end
    wait (pending_ops.size() == 0 && !s_tvalid);
    wait (answers_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
